// File: rtl/ffea_pkg.sv
// Package for the first-fit extent allocator: sizes, codes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
package ffea_pkg;
    localparam int TABLE_ENTRIES = 32;
    localparam int PAGE_BYTES    = 4096;
    localparam int ADDRESS_BITS  = 48;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS      = 6;
    localparam int PAGE_BITS     = $clog2(PAGE_BYTES) + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Per-cell action codes
    localparam logic [2:0] ACT_HOLD   = 3'd0;
    localparam logic [2:0] ACT_LOAD   = 3'd1; // write base and size from bus
    localparam logic [2:0] ACT_SIZE   = 3'd2; // write size only
    localparam logic [2:0] ACT_LEFT   = 3'd3; // take entry from right neighbor
    localparam logic [2:0] ACT_RIGHT  = 3'd4; // take entry from left neighbor

    typedef logic [ADDRESS_BITS-1:0] addr_t;

    typedef struct packed {
        logic [2:0] act;
    } cell_ctl_t;
endpackage

// File: rtl/ffea_if.sv
// Valid/ready channel interfaces for the allocator.
// Depends on ffea_pkg.
`timescale 1ns / 1ps
interface ffea_req_if;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    ffea_pkg::addr_t      request_size;
    ffea_pkg::addr_t      region_base;
    modport source (output valid, operation, request_size, region_base, input ready);
    modport sink   (input valid, operation, request_size, region_base, output ready);
endinterface

interface ffea_rsp_if;
    logic                 valid;
    logic                 ready;
    ffea_pkg::addr_t      block_address;
    logic [1:0]           status;
    logic [5:0]           free_extents;
    modport source (output valid, block_address, status, free_extents, input ready);
    modport sink   (input valid, block_address, status, free_extents, output ready);
endinterface

// File: rtl/ffea_cell.sv
// One table cell: holds one extent and shifts to or from its neighbors.
// Depends on ffea_pkg.
`timescale 1ns / 1ps
module ffea_cell (
    input  logic                clk,
    input  ffea_pkg::cell_ctl_t ctl,
    input  ffea_pkg::addr_t     bus_base,
    input  ffea_pkg::addr_t     bus_size,
    input  ffea_pkg::addr_t     left_base,
    input  ffea_pkg::addr_t     left_size,
    input  ffea_pkg::addr_t     right_base,
    input  ffea_pkg::addr_t     right_size,
    output ffea_pkg::addr_t     base,
    output ffea_pkg::addr_t     size
);
    import ffea_pkg::*;
    addr_t base_reg, size_reg, base_next, size_next;

    // next entry by action
    always_comb
    begin
        base_next = base_reg;
        size_next = size_reg;
        case (ctl.act)
            ACT_LOAD:
            begin
                base_next = bus_base;
                size_next = bus_size;
            end
            ACT_SIZE:  size_next = bus_size;
            ACT_LEFT:
            begin
                base_next = right_base;
                size_next = right_size;
            end
            ACT_RIGHT:
            begin
                base_next = left_base;
                size_next = left_size;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        size_reg <= size_next;
    end

    assign base = base_reg;
    assign size = size_reg;
endmodule

// File: rtl/first_fit_extent_allocator.sv
// Top level of the first-fit extent allocator: control, search and the cell row.
// Depends on ffea_pkg, ffea_if and ffea_cell.
//
//  channel | dir | fields
//  req     | in  | operation, request_size, region_base
//  rsp     | out | block_address, status, free_extents
//
// After the accepting edge, the S_CMP state runs the parallel compare over all cells and
// registers the results; the S_UPD state does the priority select and the shift/write of
// the cell row while the result is registered, and rsp.valid rises with that result.
// The input stays closed until that result is taken, so no new request is accepted
// while a result is still held or waits for rsp.ready.
// rst_n clears the extent count and handshake state; cell contents stay undefined.
`timescale 1ns / 1ps
module first_fit_extent_allocator (
    input  logic clk,
    input  logic rst_n,
    ffea_req_if.sink   req,
    ffea_rsp_if.source rsp
);
    import ffea_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg;
    logic                op_reg;
    addr_t               size_reg, base_reg, need_reg;
    logic                ovf_reg;
    logic                rsp_valid_reg;
    addr_t               rsp_addr_reg;
    logic [1:0]          rsp_status_reg;

    addr_t     cbase [TABLE_ENTRIES];
    addr_t     csize [TABLE_ENTRIES];
    cell_ctl_t ctl   [TABLE_ENTRIES];
    addr_t     bus_base, bus_size;

    // per-cell compare results, registered
    logic [TABLE_ENTRIES-1:0] fit_reg, lt_reg, live;
    logic [TABLE_ENTRIES-1:0] fit_c, lt_c;

    // page rounding: remainder via mask when a power of two, else compare-less constant mod
    logic [PAGE_BITS-1:0] rem;
    logic [ADDRESS_BITS:0] need_w;
    always_comb
    begin
        rem = PAGE_BITS'(req.request_size % PAGE_BYTES);
        if (rem != '0)
            need_w = {1'b0, req.request_size} + (ADDRESS_BITS+1)'(PAGE_BYTES - rem);
        else
            need_w = {1'b0, req.request_size};
    end

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;

    // cell compares
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            live[i] = CNT_BITS'(i) < count_reg;
            fit_c[i] = live[i] && (csize[i] >= need_reg);
            lt_c[i]  = live[i] && (cbase[i] < base_reg);
        end
    end

    // priority select: first fit, and insert position
    logic [IDX_BITS-1:0] fidx, pidx;
    logic                fany;
    logic [CNT_BITS-1:0] pos;
    always_comb
    begin
        fidx = '0;
        fany = 1'b0;
        for (int i = TABLE_ENTRIES-1; i >= 0; i--)
            if (fit_reg[i])
            begin
                fidx = IDX_BITS'(i);
                fany = 1'b1;
            end
        pos = CNT_BITS'($countones(lt_reg));
        pidx = pos[IDX_BITS-1:0];
    end

    logic  has_next, has_prev, t_next, t_prev;
    addr_t nb, ns, pb, ps;
    logic [IDX_BITS-1:0] pm1;
    always_comb
    begin
        pm1 = pidx - 1'b1;
        nb = cbase[pidx];
        ns = csize[pidx];
        pb = cbase[pm1];
        ps = csize[pm1];
        has_next = pos < count_reg;
        has_prev = pos != '0;
        t_next = has_next && ((nb - base_reg) == size_reg);
        t_prev = has_prev && ((base_reg - pb) == ps);
    end

    // update decisions
    logic [CNT_BITS-1:0] count_next;
    addr_t               addr_res;
    logic [1:0]          st_res;
    always_comb
    begin
        count_next = count_reg;
        addr_res = '0;
        st_res = ST_OK;
        bus_base = base_reg;
        bus_size = size_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            ctl[i].act = ACT_HOLD;
        if (state_reg == S_UPD)
        begin
            if (op_reg == OP_ALLOC)
            begin
                if (ovf_reg || !fany)
                    st_res = ST_NO_FIT;
                else if (csize[fidx] == need_reg)
                begin
                    addr_res = cbase[fidx];
                    for (int i = 0; i < TABLE_ENTRIES-1; i++)
                        if (IDX_BITS'(i) >= fidx)
                            ctl[i].act = ACT_LEFT;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    addr_res = cbase[fidx] + csize[fidx] - need_reg;
                    bus_size = csize[fidx] - need_reg;
                    ctl[fidx].act = ACT_SIZE;
                end
            end
            else if (t_prev && t_next)
            begin
                bus_size = ps + size_reg + ns;
                ctl[pm1].act = ACT_SIZE;
                for (int i = 0; i < TABLE_ENTRIES-1; i++)
                    if (IDX_BITS'(i) >= pidx)
                        ctl[i].act = ACT_LEFT;
                count_next = count_reg - 1'b1;
            end
            else if (t_prev)
            begin
                bus_size = ps + size_reg;
                ctl[pm1].act = ACT_SIZE;
            end
            else if (t_next)
            begin
                bus_size = ns + size_reg;
                ctl[pidx].act = ACT_LOAD;
            end
            else if (count_reg >= CNT_BITS'(TABLE_ENTRIES))
                st_res = ST_FULL;
            else
            begin
                for (int i = 1; i < TABLE_ENTRIES; i++)
                    if (CNT_BITS'(i) > pos)
                        ctl[i].act = ACT_RIGHT;
                ctl[pidx].act = ACT_LOAD;
                count_next = count_reg + 1'b1;
            end
        end
    end

    // cell row
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        ffea_cell u_cell (
            .clk        (clk),
            .ctl        (ctl[g]),
            .bus_base   (bus_base),
            .bus_size   (bus_size),
            .left_base  (cbase[(g+TABLE_ENTRIES-1)%TABLE_ENTRIES]),
            .left_size  (csize[(g+TABLE_ENTRIES-1)%TABLE_ENTRIES]),
            .right_base (cbase[(g+1)%TABLE_ENTRIES]),
            .right_size (csize[(g+1)%TABLE_ENTRIES]),
            .base       (cbase[g]),
            .size       (csize[g])
        );
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.valid && req.ready) state_next = S_CMP;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_UPD)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.operation;
            size_reg <= req.request_size;
            base_reg <= req.region_base;
            need_reg <= need_w[ADDRESS_BITS-1:0];
            ovf_reg  <= need_w[ADDRESS_BITS];
        end
        if (state_reg == S_CMP)
        begin
            fit_reg <= fit_c;
            lt_reg  <= lt_c;
        end
        if (state_reg == S_UPD)
        begin
            rsp_addr_reg   <= addr_res;
            rsp_status_reg <= st_res;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.block_address = rsp_addr_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.free_extents  = count_reg;
endmodule
